/* design/slpc_pkg.sv */
package slpc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_LENGTH = 2'd1;
    localparam logic [1:0] CFG_OFFSET = 2'd2;

    // Output modes
    localparam logic [1:0] MODE_MAG   = 2'd0;
    localparam logic [1:0] MODE_LN    = 2'd1;
    localparam logic [1:0] MODE_LOG10 = 2'd2;

    localparam int SAMPLE_WIDTH = 24;
    localparam int LEN_WIDTH    = 13;
    localparam int BIN_WIDTH    = 12;
    localparam logic [LEN_WIDTH-1:0] MAX_FRAME_LENGTH = 13'd4096;

    // Fixed-point constants, Q32 (log scale) and Q24 (angles)
    localparam logic signed [32:0] LN2_Q32     = 33'sd2977044472;
    localparam logic signed [32:0] LOG10_2_Q32 = 33'sd1292913986;
    localparam logic signed [32:0] LOG10E_Q32  = 33'sd1865280597;
    localparam logic signed [27:0] PI_Q24      = 28'sd52707179;

    localparam logic signed [27:0] ATAN_Q24 [0:7] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214, 28'sd524117, 28'sd262123, 28'sd131069
    };

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] re_part;
        logic signed [SAMPLE_WIDTH-1:0] im_part;
        logic [BIN_WIDTH-1:0]           bin_index;
    } t_in;

    typedef struct packed {
        logic signed [31:0] level;
        logic signed [23:0] phase;
        logic               saturated;
    } t_out;

    // Everything one item carries down the pipeline
    typedef struct packed {
        logic signed [23:0] re;
        logic signed [23:0] im;
        logic               phz;
        logic [46:0]        sqa;
        logic [46:0]        sqb;
        logic [47:0]        p;
        logic               pz;
        logic [5:0]         msb;
        logic [50:0]        rem;
        logic [50:0]        root;
        logic signed [26:0] cx;
        logic signed [26:0] cy;
        logic signed [27:0] cz;
        logic [30:0]        lx;
        logic [29:0]        lf;
        logic signed [39:0] offt;
        logic signed [59:0] zl;
        logic [61:0]        fc;
        logic signed [40:0] mc;
    } t_stage;

endpackage

/* design/slpc_level.sv */
module slpc_level (
    input  slpc_pkg::t_stage i_stage,
    input  logic [1:0]       i_mode,
    output slpc_pkg::t_out   o_result
);

    logic signed [41:0] scaled;
    logic signed [41:0] lq;
    logic signed [41:0] diff;
    logic signed [33:0] lv;
    logic signed [27:0] zr;
    logic signed [59:0] zs;
    logic signed [23:0] ph;

    // Combine log terms, remove the offset and drop to Q8.24
    always_comb begin
        scaled = 42'(i_stage.mc) + $signed({10'b0, i_stage.fc[61:30]});
        lq     = scaled >>> 1;
        diff   = lq - 42'(i_stage.offt);
        lv     = 34'(diff >>> 8);
        zr     = i_stage.cz + 28'sd8;
        zs     = i_stage.zl + (60'sd1 <<< 35);
        if (i_mode == slpc_pkg::MODE_LN) begin
            ph = 24'(zr >>> 4);
        end else begin
            ph = 24'(zs >>> 36);
        end
    end

    // Select the result by mode and clip the level
    always_comb begin
        o_result = '0;
        if (i_mode == slpc_pkg::MODE_LN || i_mode == slpc_pkg::MODE_LOG10) begin
            if (i_stage.pz) begin
                o_result.level     = 32'sh8000_0000;
                o_result.saturated = 1'b1;
            end else begin
                if (lv > 34'sd2147483647) begin
                    o_result.level     = 32'sh7FFF_FFFF;
                    o_result.saturated = 1'b1;
                end else if (lv < -34'sd2147483648) begin
                    o_result.level     = 32'sh8000_0000;
                    o_result.saturated = 1'b1;
                end else begin
                    o_result.level = 32'(lv);
                end
                if (!i_stage.phz) begin
                    o_result.phase = ph;
                end
            end
        end else begin
            o_result.level = $signed({6'b0, i_stage.root[25:0]});
        end
    end

endmodule

/* design/spectrum_log_polar_convert.sv */
// Channel   | Signals                              | Direction
// ----------+--------------------------------------+----------
// bin in    | i_in_valid, o_in_ready, i_in         | in
// result    | o_out_valid, i_out_ready, o_out      | out
// config    | i_cfg_wr_en, i_cfg_index, i_cfg_data | in
//
// One bin enters per cycle unless the output stalls; each result passes through the
// registers r_pipe[0..35] and r_out. The depth is set by the 30-step log squaring
// chain, one multiplier per stage, with CORDIC and square root stages alongside it.
// Reset clears the valid bits and loads mode 1, length 512 and a zero offset.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
module spectrum_log_polar_convert (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  slpc_pkg::t_in       i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output slpc_pkg::t_out      o_out,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    localparam int LAST = 35;

    logic [1:0]               r_mode;
    logic [12:0]              r_len;
    logic signed [31:0]       r_offset;
    logic                     r_valid [0:LAST];
    slpc_pkg::t_stage         r_pipe  [0:LAST];
    slpc_pkg::t_stage         n_pipe  [0:LAST];
    logic                     r_out_valid;
    slpc_pkg::t_out           r_out;
    slpc_pkg::t_out           n_out;
    logic                     adv;
    logic [12:0]              len_c;
    logic [11:0]              half;
    logic                     force_zero;

    // One stage of work; k picks which steps apply
    function automatic slpc_pkg::t_stage f_step(input slpc_pkg::t_stage s, input int k,
                                                input logic [1:0] mode,
                                                input logic signed [31:0] off);
        slpc_pkg::t_stage   o;
        logic signed [47:0] pre_a;
        logic signed [47:0] pre_b;
        logic signed [27:0] ang;
        logic [50:0]        rem;
        logic [50:0]        root;
        logic [50:0]        bitv;
        logic [50:0]        trial;
        logic [61:0]        lsq;
        logic [31:0]        sqv;
        logic signed [63:0] po;
        logic signed [32:0] c;
        logic signed [7:0]  mlog;
        int                 i;
        int                 j;
        o = s;
        // Squares and CORDIC pre-rotation
        if (k == 1) begin
            pre_a = 48'(s.re) * 48'(s.re);
            pre_b = 48'(s.im) * 48'(s.im);
            o.sqa = pre_a[46:0];
            o.sqb = pre_b[46:0];
            o.cx  = 27'(s.re);
            o.cy  = 27'(s.im);
            o.cz  = '0;
            if (s.re < 0) begin
                o.cz = (s.im >= 0) ? slpc_pkg::PI_Q24 : -slpc_pkg::PI_Q24;
                o.cx = -27'(s.re);
                o.cy = -27'(s.im);
            end
            o.phz = s.phz | (s.re == 0 && s.im == 0);
        end
        if (k == 2) begin
            o.p = {1'b0, s.sqa} + {1'b0, s.sqb};
        end
        // CORDIC vectoring iterations
        if (k >= 2 && k <= 25) begin
            i   = k - 2;
            ang = (i < 8) ? slpc_pkg::ATAN_Q24[i[2:0]] : (28'sd1 <<< (24 - i));
            if (s.cy >= 0) begin
                o.cx = s.cx + (s.cy >>> i);
                o.cy = s.cy - (s.cx >>> i);
                o.cz = s.cz + ang;
            end else begin
                o.cx = s.cx - (s.cy >>> i);
                o.cy = s.cy + (s.cx >>> i);
                o.cz = s.cz - ang;
            end
        end
        // Leading one of the power
        if (k == 3) begin
            o.pz  = (s.p == '0);
            o.msb = '0;
            for (int b = 0; b < 48; b++) begin
                if (s.p[b]) begin
                    o.msb = 6'(b);
                end
            end
        end
        // Square root, one result bit per stage
        if (k >= 3 && k <= 27) begin
            j     = k - 3;
            rem   = (k == 3) ? {1'b0, s.p, 2'b0} : s.rem;
            root  = (k == 3) ? '0 : s.root;
            bitv  = 51'(1) << (48 - 2 * j);
            trial = root + bitv;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            o.rem  = rem;
            o.root = root;
        end
        // Normalize to a leading one at bit 30
        if (k == 4) begin
            if (s.msb >= 6'd30) begin
                o.lx = 31'(s.p >> (s.msb - 6'd30));
            end else begin
                o.lx = 31'(s.p << (6'd30 - s.msb));
            end
            o.lf = '0;
        end
        // Log fraction by repeated squaring
        if (k >= 5 && k <= 34) begin
            lsq  = 62'(s.lx) * 62'(s.lx);
            sqv  = lsq[61:30];
            o.lf = {s.lf[28:0], 1'b0};
            if (sqv[31]) begin
                o.lx    = sqv[31:1];
                o.lf[0] = 1'b1;
            end else begin
                o.lx = sqv[30:0];
            end
        end
        // Offset term in level units
        if (k == 20) begin
            if (mode == slpc_pkg::MODE_LOG10) begin
                po     = 64'(off) * 64'(slpc_pkg::LOG10E_Q32);
                o.offt = 40'(po >>> 24);
            end else begin
                o.offt = {off, 8'b0};
            end
        end
        if (k == 26) begin
            o.zl = 60'(s.cz) * 60'(slpc_pkg::LOG10E_Q32);
        end
        // Scale log2 by the base constant
        if (k == 35) begin
            c    = (mode == slpc_pkg::MODE_LOG10) ? slpc_pkg::LOG10_2_Q32 : slpc_pkg::LN2_Q32;
            o.fc = 62'(s.lf) * 62'(c[31:0]);
            mlog = $signed({2'b0, s.msb}) - 8'sd46;
            o.mc = 41'(mlog) * 41'(c);
        end
        return o;
    endfunction

    // Bin 0 and Nyquist bin detection
    always_comb begin
        len_c      = (r_len > slpc_pkg::MAX_FRAME_LENGTH) ? slpc_pkg::MAX_FRAME_LENGTH : r_len;
        half       = len_c[12:1];
        force_zero = (i_in.bin_index == '0) || (!len_c[0] && i_in.bin_index == half);
    end

    always_comb begin
        n_pipe[0]     = '0;
        n_pipe[0].re  = i_in.re_part;
        n_pipe[0].im  = i_in.im_part;
        n_pipe[0].phz = force_zero;
    end

    for (genvar k = 1; k <= LAST; k++) begin : g_stage
        assign n_pipe[k] = f_step(r_pipe[k-1], k, r_mode, r_offset);
    end

    slpc_level u_level (
        .i_stage  (r_pipe[LAST]),
        .i_mode   (r_mode),
        .o_result (n_out)
    );

    // Advance everything when the output register can take a transfer
    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= slpc_pkg::MODE_LN;
            r_len       <= 13'd512;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= LAST; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    slpc_pkg::CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                    slpc_pkg::CFG_LENGTH: r_len    <= i_cfg_data[12:0];
                    slpc_pkg::CFG_OFFSET: r_offset <= i_cfg_data;
                    default: ;
                endcase
            end
            if (adv) begin
                r_valid[0] <= i_in_valid;
                for (int k = 1; k <= LAST; k++) begin
                    r_valid[k] <= r_valid[k-1];
                end
                r_out_valid <= r_valid[LAST];
            end
        end
    end

    // Hold payload on stall
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k <= LAST; k++) begin
                r_pipe[k] <= n_pipe[k];
            end
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
